>>> sv/cdd_pkg.sv
`default_nettype none

package cdd_pkg;

  localparam int IN_BITS  = 43;
  localparam int OUT_BITS = 25;

  localparam logic [2:0] OP_DAYS       = 3'd0;
  localparam logic [2:0] OP_WEEKS      = 3'd1;
  localparam logic [2:0] OP_MONTHS     = 3'd2;
  localparam logic [2:0] OP_YEARS      = 3'd3;
  localparam logic [2:0] OP_DECADES    = 3'd4;
  localparam logic [2:0] OP_CENTURY    = 3'd5;
  localparam logic [2:0] OP_MILLENNIUM = 3'd6;

  localparam logic [15:0] INV25     = 16'h5C29;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  typedef struct packed {
    logic signed [15:0] start_year;
    logic [3:0]         start_month;
    logic [4:0]         start_day;
    logic [14:0]        step_count;
    logic [2:0]         opcode;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] result_year;
    logic [3:0]         result_month;
    logic [4:0]         result_day;
  } out_word_t;

  typedef enum logic [3:0] {
    U_NONE,
    U_LOAD,
    U_CLAMP,
    U_BORROW,
    U_FILL,
    U_LAST,
    U_MSTEP,
    U_YSUB,
    U_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_IN,
    C_ALWAYS,
    C_ROUTE,
    C_NGED,
    C_NZERO,
    C_OFREE
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t S_IDLE     = 3'd0;
  localparam step_t S_CLAMP    = 3'd1;
  localparam step_t S_DAY      = 3'd2;
  localparam step_t S_DAYFILL  = 3'd3;
  localparam step_t S_MON      = 3'd4;
  localparam step_t S_MONCLAMP = 3'd5;
  localparam step_t S_YEAR     = 3'd6;
  localparam step_t S_DONE     = 3'd7;

  typedef struct packed {
    cond_t cond;
    uop_t  uop_true;
    step_t next_true;
    uop_t  uop_false;
    step_t next_false;
  } ucw_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       n_ge_d;
    logic       n_zero;
  } dp_status_t;

  function automatic ucw_t ucode(input step_t pc);
    ucw_t w;
    unique case (pc)
      S_IDLE:     w = '{C_IN,     U_LOAD,   S_CLAMP,    U_NONE, S_IDLE};
      S_CLAMP:    w = '{C_ROUTE,  U_CLAMP,  S_IDLE,     U_NONE, S_IDLE};
      S_DAY:      w = '{C_NGED,   U_BORROW, S_DAYFILL,  U_LAST, S_DONE};
      S_DAYFILL:  w = '{C_ALWAYS, U_FILL,   S_DAY,      U_NONE, S_DAY};
      S_MON:      w = '{C_NZERO,  U_MSTEP,  S_MONCLAMP, U_NONE, S_DONE};
      S_MONCLAMP: w = '{C_ALWAYS, U_CLAMP,  S_MON,      U_NONE, S_MON};
      S_YEAR:     w = '{C_ALWAYS, U_YSUB,   S_DONE,     U_NONE, S_DONE};
      S_DONE:     w = '{C_OFREE,  U_EMIT,   S_IDLE,     U_NONE, S_DONE};
      default:    w = '{C_ALWAYS, U_NONE,   S_IDLE,     U_NONE, S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t route(input logic [2:0] opcode);
    step_t s;
    unique case (opcode)
      OP_DAYS, OP_WEEKS: s = S_DAY;
      OP_MONTHS:         s = S_MON;
      default:           s = S_YEAR;
    endcase
    return s;
  endfunction

  // Divisibility by 25 uses the modular inverse of 25 on the magnitude.
  function automatic logic is_leap(input logic signed [15:0] y);
    logic [15:0] a;
    logic [15:0] p;
    logic        d4;
    logic        d16;
    logic        d25;
    a   = y[15] ? 16'(~y + 16'sd1) : 16'(y);
    p   = 16'(a * INV25);
    d4  = (a[1:0] == 2'd0);
    d16 = (a[3:0] == 4'd0);
    d25 = (p <= DIV25_MAX);
    return (d16 && d25) || (d4 && !d25);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic signed [15:0] y);
    logic [4:0] r;
    unique case (m)
      4'd2:                    r = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/cdd_datapath.sv
`default_nettype none

module cdd_datapath (
  input  wire logic                clk,
  input  wire cdd_pkg::uop_t       uop,
  input  wire cdd_pkg::in_word_t   in_word,
  output cdd_pkg::dp_status_t      status,
  output cdd_pkg::out_word_t       result
);
  import cdd_pkg::*;

  logic [2:0]         op;
  logic [4:0]         d;
  logic [3:0]         m;
  logic signed [15:0] y;
  logic [17:0]        n;

  logic [4:0]         lim;
  logic [3:0]         m_prev;
  logic signed [15:0] y_prev;
  logic [17:0]        n_load;
  logic [3:0]         m_load;

  assign lim    = days_in(m, y);
  assign m_prev = (m == 4'd1) ? 4'd12 : m - 4'd1;
  assign y_prev = (m == 4'd1) ? y - 16'sd1 : y;

  always_comb begin
    unique case (in_word.opcode)
      OP_DAYS, OP_MONTHS, OP_YEARS: n_load = 18'(in_word.step_count);
      OP_WEEKS:      n_load = 18'(in_word.step_count) * 18'd7;
      OP_DECADES:    n_load = 18'(16'(in_word.step_count) * 16'd10);
      OP_CENTURY:    n_load = 18'd100;
      OP_MILLENNIUM: n_load = 18'd1000;
      default:       n_load = '0;
    endcase
  end

  always_comb begin
    priority if (in_word.start_month == 4'd0) begin
      m_load = 4'd1;
    end else if (in_word.start_month > 4'd12) begin
      m_load = 4'd12;
    end else begin
      m_load = in_word.start_month;
    end
  end

  always_ff @(posedge clk) begin
    unique case (uop)
      U_LOAD: begin
        op <= in_word.opcode;
        m  <= m_load;
        d  <= (in_word.start_day == 5'd0) ? 5'd1 : in_word.start_day;
        y  <= in_word.start_year;
        n  <= n_load;
      end
      U_CLAMP: begin
        if (d > lim) begin
          d <= lim;
        end
      end
      U_BORROW: begin
        n <= n - 18'(d);
        m <= m_prev;
        y <= y_prev;
      end
      U_FILL: d <= lim;
      U_LAST: d <= d - n[4:0];
      U_MSTEP: begin
        n <= n - 18'd1;
        m <= m_prev;
        y <= y_prev;
      end
      U_YSUB: y <= y - signed'(n[15:0]);
      default: begin
      end
    endcase
  end

  assign status.opcode = op;
  assign status.n_ge_d = (n >= 18'(d));
  assign status.n_zero = (n == 18'd0);

  assign result.result_year  = y;
  assign result.result_month = m;
  assign result.result_day   = d;

endmodule

`default_nettype wire

>>> sv/calendar_date_decrement.sv
// Channel  Direction  Payload (lowest bit first)
// s_       in         opcode, step_count, start_day, start_month, start_year
// m_       out        result_day, result_month, result_year
//
// A year, decade, century or millennium word passes the load, clamp, year and emit steps.
// Day and week words add a borrow and a fill for every month boundary crossed.
// Month words add a month step and a clamp per month in the microcode loop.
// Reset returns the step counter to idle and drops m_tvalid.
// A stalled result waits in the output register while the next word is taken.

`default_nettype none

module calendar_date_decrement (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // opcode, step_count, start_day, start_month, start_year
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // result_day, result_month, result_year
);
  import cdd_pkg::*;

  step_t      pc;
  step_t      pc_next;
  ucw_t       cw;
  logic       taken;
  uop_t       uop;
  in_word_t   in_word;
  dp_status_t status;
  out_word_t  result;
  out_word_t  out_reg;

  assign in_word  = in_word_t'(s_tdata[IN_BITS-1:0]);
  assign s_tready = (pc == S_IDLE);
  assign cw       = ucode(pc);

  always_comb begin
    unique case (cw.cond)
      C_IN:    taken = s_tvalid;
      C_NGED:  taken = status.n_ge_d;
      C_NZERO: taken = !status.n_zero;
      C_OFREE: taken = !m_tvalid || m_tready;
      default: taken = 1'b1;
    endcase
    uop = taken ? cw.uop_true : cw.uop_false;
    if (cw.cond == C_ROUTE) begin
      pc_next = route(status.opcode);
    end else begin
      pc_next = taken ? cw.next_true : cw.next_false;
    end
  end

  cdd_datapath u_datapath (
    .clk     (clk),
    .uop     (uop),
    .in_word (in_word),
    .status  (status),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uop == U_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uop == U_EMIT) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {(32 - OUT_BITS)'(0), out_reg};

endmodule

`default_nettype wire

>>> sv/cdd_checker.sv
`default_nettype none

module cdd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] != 5'd0)
    else $error("result day is zero");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12))
    else $error("result month out of range");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after an input word");

endmodule

bind calendar_date_decrement cdd_checker u_cdd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
